/* src/liu_adj_pkg.sv */
package liu_adj_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int VALUE_W    = 32;
  localparam int ACC_W      = 48;
  localparam int GAIN_W     = 25;
  localparam int FACTOR_W   = 6;
  localparam int PHASE_W    = 5;
  localparam int MAX_FACTOR = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int FRAC_W     = 24;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_FACTOR = 2'd1,
    REG_GAIN   = 2'd2
  } reg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the input beat
    logic f_pair;     // open a forward interval from prev and cur
    logic f_final;    // load the trace-end term cur*F
    logic save_prev;  // cur becomes the previous coarse sample
    logic clear;      // return the trace state to its reset value
    logic a_prod;     // form the two adjoint weight products
    logic a_acc;      // fold the products into the accumulators
    logic mul;        // scale the operand by gain
    logic step;       // advance the forward operand by one fine sample
    logic emit;       // load the output register
    logic out_last;
    logic out_done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_prev;
    logic trace_end;
    logic mode;
    logic k_last;
    logic a_emit;
    logic out_free;
  } sts_t;

endpackage

/* src/liu_adj_in_if.sv */
interface liu_adj_in_if import liu_adj_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       trace_end;

  modport source (output valid, output sample, output trace_end, input ready);
  modport sink (input valid, input sample, input trace_end, output ready);
endinterface

/* src/liu_adj_out_if.sv */
interface liu_adj_out_if import liu_adj_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      run_last;
  logic                      trace_done;
  logic                      misaligned;

  modport source (output valid, output value, output run_last, output trace_done,
                  output misaligned, input ready);
  modport sink (input valid, input value, input run_last, input trace_done,
                input misaligned, output ready);
endinterface

/* src/liu_adj_cfg_if.sv */
interface liu_adj_cfg_if import liu_adj_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/liu_adj_ctrl.sv */
module liu_adj_ctrl import liu_adj_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FPREP = 6'b000010,
    S_APROD = 6'b000100,
    S_AACC  = 6'b001000,
    S_MUL   = 6'b010000,
    S_SUM   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   is_final, is_final_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    is_final_next = is_final;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = sts.mode ? S_APROD : S_FPREP;
        end
      end
      S_FPREP: begin
        if (sts.have_prev) begin
          cmd.f_pair    = 1'b1;
          is_final_next = 1'b0;
          state_next    = S_MUL;
        end else if (sts.trace_end) begin
          cmd.f_final   = 1'b1;
          is_final_next = 1'b1;
          state_next    = S_MUL;
        end else begin
          cmd.save_prev = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_APROD: begin
        cmd.a_prod = 1'b1;
        state_next = S_AACC;
      end
      S_AACC: begin
        cmd.a_acc  = 1'b1;
        state_next = sts.a_emit ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.mode) begin
            cmd.out_last = 1'b1;
            cmd.out_done = sts.trace_end;
            state_next   = S_IDLE;
          end else if (is_final) begin
            cmd.out_last = 1'b1;
            cmd.out_done = 1'b1;
            cmd.clear    = 1'b1;
            state_next   = S_IDLE;
          end else if (!sts.k_last) begin
            cmd.step   = 1'b1;
            state_next = S_MUL;
          end else if (sts.trace_end) begin
            // The interval is done; the trace-end term follows.
            cmd.clear  = 1'b1;
            state_next = S_FPREP;
          end else begin
            cmd.out_last  = 1'b1;
            cmd.save_prev = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      is_final <= 1'b0;
    end else begin
      state    <= state_next;
      is_final <= is_final_next;
    end
  end

endmodule

/* src/liu_adj_dp.sv */
module liu_adj_dp import liu_adj_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_trace_end,
  input  logic                       cfg_valid,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic                       out_run_last,
  output logic                       out_trace_done,
  output logic                       out_misaligned
);

  localparam int PROD_W = SAMPLE_W + FACTOR_W + 1;
  localparam int HALF_W = ACC_W - FRAC_W;
  localparam int PLO_W  = FRAC_W + GAIN_W;
  localparam int PHI_W  = HALF_W + GAIN_W + 1;
  localparam int SUM_W  = PHI_W + 1;

  // Configuration.
  logic                mode;
  logic [FACTOR_W-1:0] factor;
  logic [GAIN_W-1:0]   gain;

  // Trace state.
  logic signed [SAMPLE_W-1:0] prev;
  logic                       have_prev;
  logic [PHASE_W-1:0]         phase;
  logic signed [ACC_W-1:0]    acc_cur;
  logic signed [ACC_W-1:0]    acc_fol;

  // Working registers of the current item.
  logic signed [SAMPLE_W-1:0] cur;
  logic                       end_r;
  logic signed [SAMPLE_W:0]   delta;
  logic [PHASE_W-1:0]         kcnt;
  logic signed [ACC_W-1:0]    x;
  logic                       mis_r;
  logic signed [PROD_W-1:0]   wc;
  logic signed [PROD_W-1:0]   wf;
  logic [PLO_W-1:0]           p_lo;
  logic signed [PHI_W-1:0]    p_hi;

  logic [FACTOR_W-1:0]      f_eff;
  logic [PHASE_W-1:0]       fm1;
  logic [PHASE_W-1:0]       kcl;
  logic signed [ACC_W:0]    sum_c;
  logic signed [ACC_W:0]    sum_f;
  logic signed [ACC_W-1:0]  sat_c;
  logic signed [ACC_W-1:0]  sat_f;
  logic signed [PROD_W-1:0] f_mul;
  logic signed [SUM_W-1:0]  scaled;
  logic signed [VALUE_W-1:0] scaled_sat;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    if (factor == '0) begin
      f_eff = FACTOR_W'(1);
    end else if (factor > FACTOR_W'(MAX_FACTOR)) begin
      f_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      f_eff = factor;
    end
  end

  assign fm1   = PHASE_W'(f_eff - FACTOR_W'(1));
  assign kcl   = (phase > fm1) ? fm1 : phase;
  assign sum_c = (ACC_W+1)'(acc_cur) + (ACC_W+1)'(wc);
  assign sum_f = (ACC_W+1)'(acc_fol) + (ACC_W+1)'(wf);
  assign sat_c = sat_acc(sum_c);
  assign sat_f = sat_acc(sum_f);

  // Forward operand: prev*F when an interval opens, cur*F for the trace-end term.
  assign f_mul = (have_prev ? prev : cur) * $signed({1'b0, f_eff});

  // floor(x*gain / 2^24) from the two halves of x, then clamped to 32 bits.
  assign scaled = SUM_W'(p_hi) + SUM_W'($signed({1'b0, p_lo[PLO_W-1:FRAC_W]}));
  always_comb begin
    if (scaled > SUM_W'(32'sh7FFF_FFFF)) begin
      scaled_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end else if (scaled < -SUM_W'(33'sh0_8000_0000)) begin
      scaled_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      scaled_sat = scaled[VALUE_W-1:0];
    end
  end

  assign sts.have_prev = have_prev;
  assign sts.trace_end = end_r;
  assign sts.mode      = mode;
  assign sts.k_last    = (kcnt == fm1);
  assign sts.a_emit    = end_r || (kcl == fm1);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 1'b0;
      factor <= FACTOR_W'(1);
      gain   <= GAIN_W'(1) << FRAC_W;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   mode   <= cfg_data[0];
        REG_FACTOR: factor <= cfg_data[FACTOR_W-1:0];
        REG_GAIN:   gain   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      have_prev <= 1'b0;
      phase     <= '0;
      acc_cur   <= '0;
      acc_fol   <= '0;
    end else if (cmd.clear) begin
      prev      <= '0;
      have_prev <= 1'b0;
      phase     <= '0;
      acc_cur   <= '0;
      acc_fol   <= '0;
    end else if (cmd.save_prev) begin
      prev      <= cur;
      have_prev <= 1'b1;
    end else if (cmd.a_acc) begin
      if (end_r) begin
        prev      <= '0;
        have_prev <= 1'b0;
        phase     <= '0;
        acc_cur   <= '0;
        acc_fol   <= '0;
      end else if (kcl == fm1) begin
        acc_cur <= sat_f;
        acc_fol <= '0;
        phase   <= '0;
      end else begin
        acc_cur <= sat_c;
        acc_fol <= sat_f;
        phase   <= kcl + PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur   <= in_sample;
      end_r <= in_trace_end;
    end
    if (cmd.f_pair) begin
      x     <= ACC_W'(f_mul);
      delta <= (SAMPLE_W+1)'(cur) - (SAMPLE_W+1)'(prev);
      kcnt  <= '0;
      mis_r <= 1'b0;
    end else if (cmd.f_final) begin
      x     <= ACC_W'(f_mul);
      mis_r <= 1'b0;
    end else if (cmd.step) begin
      x    <= x + ACC_W'(delta);
      kcnt <= kcnt + PHASE_W'(1);
    end else if (cmd.a_acc) begin
      x     <= sat_c;
      mis_r <= end_r && (phase != '0);
    end
    if (cmd.a_prod) begin
      wc <= cur * $signed({1'b0, f_eff - FACTOR_W'(kcl)});
      wf <= cur * $signed({2'b0, kcl});
    end
    if (cmd.mul) begin
      p_lo <= x[FRAC_W-1:0] * gain;
      p_hi <= $signed(x[ACC_W-1:FRAC_W]) * $signed({1'b0, gain});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value      <= scaled_sat;
      out_run_last   <= cmd.out_last;
      out_trace_done <= cmd.out_done;
      out_misaligned <= mis_r && cmd.out_done;
    end
  end

endmodule

/* src/linear_interp_upsampler_adjoint_core.sv */
// Linear-interpolation upsampler with an adjoint accumulation mode.
// Channels: din carries one sample per beat with a trace_end mark, dout carries
// result beats (value, run_last, trace_done, misaligned), and cfg writes the
// mode, factor and gain registers; cfg is ready whenever reset is released.
// The user must write cfg only while the block is idle; the block itself does
// not enforce this. In forward mode each coarse sample after the first yields
// F fine results, each through the multiply and sum steps of the scaling unit,
// and a sample that ends the trace adds the extra trace-end term. In adjoint
// mode an item forms the weight products and folds them into the accumulators
// and uses the scaling unit only to complete an interval or end the trace. The
// shared scaling unit splits the 48-bit operand into two 24-bit halves,
// multiplies both by gain into registers and adds the partial products. din is
// ready only while the controller waits for a new item, but a finished result
// may still sit in the output register then. When the receiver stalls, the
// output register holds its beat and the controller waits before loading the
// next one. A synchronous reset holds din and cfg not ready, clears the trace
// state and accumulators and loads mode 0, factor 1 and unity gain.
module linear_interp_upsampler_adjoint_core import liu_adj_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  liu_adj_in_if.sink   din,
  liu_adj_out_if.source dout,
  liu_adj_cfg_if.sink  cfg
);

  cmd_t cmd;
  sts_t sts;

  // The register file never stalls a write once reset is released.
  assign cfg.ready = !rst;

  // The controller sequences one item at a time through the datapath.
  liu_adj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds configuration, trace state, the scaling unit and the
  // output register.
  liu_adj_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (din.sample),
    .in_trace_end   (din.trace_end),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready),
    .out_value      (dout.value),
    .out_run_last   (dout.run_last),
    .out_trace_done (dout.trace_done),
    .out_misaligned (dout.misaligned)
  );

endmodule

/* dv/linear_interp_upsampler_adjoint_core_tb.sv */
module linear_interp_upsampler_adjoint_core_tb;
  import liu_adj_pkg::*;

  // Longest random wait of either side, in cycles.
  localparam int GAP_MAX = 12;
  // Length of the one long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 300;
  // Quiet time before a register write, long enough for an item that makes
  // no result (a first forward sample, a mid-interval adjoint sample) to finish.
  localparam int SETTLE_CYCLES = 80;
  // Quiet time at the end, to catch stray result beats.
  localparam int TAIL_CYCLES = 100;
  // The watchdog gives up after this many cycles without any beat.
  localparam int STALL_LIMIT = 4000;
  // Rough size of the random part, in input beats.
  localparam int RANDOM_ITEMS = 250;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 25'h100_0000;
  localparam logic [GAIN_W-1:0] GAIN_TOP = 25'h1FF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam longint ACC_TOP = 64'sd140737488355327;
  localparam longint ACC_BOT = -64'sd140737488355328;
  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_ADJ = 1'b1;

  // One result beat as the block should present it.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      run_last;
    logic                      trace_done;
    logic                      misaligned;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst;

  liu_adj_in_if  din_if ();
  liu_adj_out_if dout_if ();
  liu_adj_cfg_if cfg_if ();

  linear_interp_upsampler_adjoint_core u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if),
    .cfg  (cfg_if)
  );

  always #2 clk = ~clk;

  // Result beats still owed by the block, oldest first.
  result_beat_t due_beats[$];

  // Our copy of the configuration registers, as last written.
  logic                cfg_mode;
  logic [FACTOR_W-1:0] cfg_factor;
  logic [GAIN_W-1:0]   cfg_gain;

  // Our copy of the trace state.
  logic signed [SAMPLE_W-1:0] prev_coarse;
  logic                       prev_valid;
  logic [PHASE_W-1:0]         interval_phase;
  logic signed [ACC_W-1:0]    acc_now;
  logic signed [ACC_W-1:0]    acc_next;

  // Handshake control shared by the stimulus and the receiver.
  logic din_busy    = 1'b0;  // din valid was left high after the last beat
  bit   src_burst   = 1'b0;  // sender offers items back to back
  bit   snk_burst   = 1'b0;  // receiver keeps ready high
  bit   hold_request = 1'b0; // receiver should start a long hold-off

  int errors       = 0;
  int items_sent   = 0;
  int beats_seen   = 0;
  int fwd_traces   = 0;
  int adj_traces   = 0;
  int misaligned_ends = 0;
  int cfg_writes   = 0;
  int holds_done   = 0;
  int idle_cycles  = 0;

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Factor as the block uses it: zero counts as one, and anything above the
  // largest supported factor is clipped to it.
  function automatic int effective_factor();
    if (cfg_factor == 0) return 1;
    if (cfg_factor > MAX_FACTOR) return MAX_FACTOR;
    return int'(cfg_factor);
  endfunction

  // Multiply by gain, scale by 2^-24 rounding toward minus infinity, and
  // saturate to the 32-bit output range. The product is formed exactly in
  // 80 bits, so the arithmetic shift is the floor.
  function automatic logic signed [VALUE_W-1:0] apply_gain(input logic signed [ACC_W-1:0] x);
    logic signed [79:0] xs;
    logic signed [79:0] gs;
    logic signed [79:0] p;
    xs = x;
    gs = {55'd0, cfg_gain};
    p = (xs * gs) >>> FRAC_W;
    if (p > 80'sd2147483647) return {1'b0, {(VALUE_W-1){1'b1}}};
    if (p < -80'sd2147483648) return {1'b1, {(VALUE_W-1){1'b0}}};
    return p[VALUE_W-1:0];
  endfunction

  // The adjoint accumulators saturate at the signed 48-bit limits.
  function automatic logic signed [ACC_W-1:0] clamp_acc(input longint s);
    if (s > ACC_TOP) return ACC_TOP[ACC_W-1:0];
    if (s < ACC_BOT) return ACC_BOT[ACC_W-1:0];
    return s[ACC_W-1:0];
  endfunction

  function automatic void clear_trace();
    prev_coarse    = '0;
    prev_valid     = 1'b0;
    interval_phase = '0;
    acc_now        = '0;
    acc_next       = '0;
  endfunction

  // Works out the result beats that one accepted input beat causes and
  // appends them to due_beats. Forward mode interpolates between the saved
  // coarse sample and the new one; adjoint mode spreads the fine sample over
  // the two accumulators with the same triangular weights.
  task automatic upsample_predict(input logic signed [SAMPLE_W-1:0] s, input logic tend);
    result_beat_t run[$];
    int f;
    int k;
    logic signed [ACC_W-1:0] v;
    f = effective_factor();
    if (cfg_mode == MODE_FWD) begin
      if (prev_valid) begin
        for (k = 0; k < f; k++) begin
          v = ACC_W'(longint'(prev_coarse) * (f - k) + longint'(s) * k);
          run.push_back('{apply_gain(v), 1'b0, 1'b0, 1'b0});
        end
      end
      if (tend) begin
        v = ACC_W'(longint'(s) * f);
        run.push_back('{apply_gain(v), 1'b0, 1'b1, 1'b0});
        fwd_traces++;
        clear_trace();
      end else begin
        prev_coarse = s;
        prev_valid  = 1'b1;
      end
    end else begin
      // A phase left beyond the end of a shortened interval acts as its
      // last phase and closes the interval.
      k = int'(interval_phase);
      if (k > f - 1) k = f - 1;
      acc_now  = clamp_acc(longint'(acc_now) + longint'(s) * (f - k));
      acc_next = clamp_acc(longint'(acc_next) + longint'(s) * k);
      if (tend) begin
        run.push_back('{apply_gain(acc_now), 1'b0, 1'b1, interval_phase != 0});
        adj_traces++;
        if (interval_phase != 0) misaligned_ends++;
        clear_trace();
      end else if (k >= f - 1) begin
        run.push_back('{apply_gain(acc_now), 1'b0, 1'b0, 1'b0});
        acc_now        = acc_next;
        acc_next       = '0;
        interval_phase = '0;
      end else begin
        interval_phase = PHASE_W'(k + 1);
      end
    end
    if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
    foreach (run[i]) due_beats.push_back(run[i]);
  endtask

  // ------------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------------

  // Offers one sample beat after a random gap and waits for it to be taken.
  // Valid is left high on return, so that a following beat with no gap
  // keeps it high instead of dropping it for a moment.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic tend);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      if (din_busy) din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.sample    <= s;
    din_if.trace_end <= tend;
    do @(posedge clk); while (!din_if.ready);
    din_busy = 1'b1;
    items_sent++;
    upsample_predict(s, tend);
  endtask

  task automatic din_idle();
    if (din_busy) begin
      din_if.valid <= 1'b0;
      din_busy = 1'b0;
    end
  endtask

  // The sender stops and waits until every owed result beat has been taken.
  task automatic wait_drained();
    din_idle();
    while (due_beats.size() != 0) @(posedge clk);
  endtask

  // Writes all three registers, only once the block has gone quiet.
  task automatic set_config(input logic m, input logic [FACTOR_W-1:0] f,
                            input logic [GAIN_W-1:0] g);
    reg_idx_t              idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    int                    i;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    idx = '{REG_MODE, REG_FACTOR, REG_GAIN};
    val = '{CFG_DATA_W'(m), CFG_DATA_W'(f), CFG_DATA_W'(g)};
    cfg_if.valid <= 1'b1;
    for (i = 0; i < 3; i++) begin
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk); while (!cfg_if.ready);
      case (idx[i])
        REG_MODE:   cfg_mode   = val[i][0];
        REG_FACTOR: cfg_factor = val[i][FACTOR_W-1:0];
        REG_GAIN:   cfg_gain   = val[i][GAIN_W-1:0];
        default: ;
      endcase
      cfg_writes++;
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly full-range random samples, with the extremes and small values
  // mixed in.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return {{(SAMPLE_W-5){r[4]}}, r[4:0]};
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Registers as they come out of reset: forward mode, factor one, unity gain.
  task automatic test_reset_config();
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
  endtask

  // Forward cases: a trace of one sample, a first sample that makes no
  // result, full-scale steps, factor zero with zero gain, and an oversized
  // factor with the largest gain.
  task automatic test_forward_cases();
    set_config(MODE_FWD, 6'd4, UNITY_GAIN);
    send_sample(-24'sd1, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    set_config(MODE_FWD, 6'd0, '0);
    send_sample(24'sd123, 1'b0);
    send_sample(-24'sd7, 1'b1);
    set_config(MODE_FWD, 6'd63, GAIN_TOP);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
  endtask

  // Adjoint cases: factor one, where every sample closes an interval; an
  // aligned end with factor two; and a misaligned end at the largest factor
  // and gain, which drives the output into saturation.
  task automatic test_adjoint_cases();
    int i;
    set_config(MODE_ADJ, 6'd1, UNITY_GAIN);
    send_sample(SAMPLE_MIN, 1'b1);
    set_config(MODE_ADJ, 6'd2, UNITY_GAIN);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(24'sd1, 1'b0);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sd0, 1'b1);
    set_config(MODE_ADJ, 6'd32, GAIN_TOP);
    for (i = 0; i < 5; i++) send_sample(SAMPLE_MAX, i == 4);
  endtask

  // The factor shrinks while an adjoint interval is open: the phase left
  // behind lies past the new last phase and must close the interval.
  task automatic test_factor_change();
    set_config(MODE_ADJ, 6'd4, UNITY_GAIN);
    send_sample(24'sd1000, 1'b0);
    send_sample(-24'sd3000, 1'b0);
    send_sample(24'sd77, 1'b0);
    set_config(MODE_ADJ, 6'd2, UNITY_GAIN);
    send_sample(24'sd5, 1'b0);
    send_sample(-24'sd9, 1'b1);
  endtask

  // The mode flips mid-trace: each mode keeps working on its own state.
  task automatic test_mode_change();
    set_config(MODE_FWD, 6'd3, UNITY_GAIN);
    send_sample(24'sd1000, 1'b0);
    set_config(MODE_ADJ, 6'd3, UNITY_GAIN);
    send_sample(24'sd40, 1'b0);
    send_sample(-24'sd40, 1'b0);
    set_config(MODE_FWD, 6'd3, UNITY_GAIN);
    send_sample(-24'sd1000, 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the block fills and stalls din; later the sender stops
  // mid-trace until every owed beat has been taken.
  task automatic test_backpressure();
    int i;
    set_config(MODE_FWD, 6'd3, UNITY_GAIN);
    src_burst    = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 16; i++) send_sample(rand_sample(), i == 15);
    src_burst = 1'b0;
    set_config(MODE_ADJ, 6'd3, UNITY_GAIN);
    for (i = 0; i < 4; i++) send_sample(rand_sample(), 1'b0);
    wait_drained();
    for (i = 0; i < 3; i++) send_sample(rand_sample(), i == 2);
  endtask

  // A stretch with no idling on either side.
  task automatic test_full_rate();
    int i;
    set_config(MODE_ADJ, 6'd2, UNITY_GAIN);
    src_burst = 1'b1;
    snk_burst = 1'b1;
    for (i = 0; i < 20; i++) send_sample(rand_sample(), i == 19);
    set_config(MODE_FWD, 6'd2, UNITY_GAIN);
    for (i = 0; i < 10; i++) send_sample(rand_sample(), i == 9);
    src_burst = 1'b0;
    snk_burst = 1'b0;
  endtask

  // One random trace in the current mode. Most are well formed; adjoint
  // traces are often sized to end exactly at the start of an interval. Now
  // and then a trace is left open, so that its state runs into the next one,
  // possibly across a register change.
  task automatic random_trace();
    int f;
    int len;
    int choice;
    int i;
    f = effective_factor();
    choice = $urandom_range(0, 9);
    if (cfg_mode == MODE_FWD) begin
      len = (choice == 0) ? 1 : $urandom_range(2, (f > 16) ? 3 : 5);
    end else if (choice < 5) begin
      len = ((f > 8) ? 1 : $urandom_range(1, 2)) * f + 1;
    end else begin
      len = $urandom_range(1, (2 * f > 40) ? 40 : 2 * f);
    end
    for (i = 0; i < len; i++) send_sample(rand_sample(), (i == len - 1) && (choice != 9));
  endtask

  // Random settings, small factors most of the time, with the extremes of
  // factor and gain drawn now and then.
  task automatic test_random();
    int start;
    int ntr;
    logic [FACTOR_W-1:0] f;
    logic [GAIN_W-1:0] g;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: f = 6'd0;
        1: f = 6'd63;
        2: f = 6'd32;
        3, 4, 5: f = FACTOR_W'($urandom_range(9, 31));
        default: f = FACTOR_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0: g = '0;
        1: g = GAIN_TOP;
        2, 3: g = UNITY_GAIN;
        default: g = GAIN_W'($urandom_range(0, 32'h1FF_FFFF));
      endcase
      set_config(1'($urandom_range(0, 1)), f, g);
      ntr = $urandom_range(2, 6);
      repeat (ntr) begin
        random_trace();
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  // The receiver draws a wait before each beat. A pending hold request turns
  // that wait into one long hold-off.
  initial begin : receiver
    int w;
    dout_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        w = HOLD_CYCLES;
        hold_request = 1'b0;
        holds_done++;
      end else if (snk_burst) begin
        w = 0;
      end else begin
        w = $urandom_range(0, GAP_MAX);
      end
      if (w > 0) begin
        dout_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
      do @(posedge clk); while (!(dout_if.valid && !rst));
    end
  end

  // Every result beat is checked field by field against the oldest owed one.
  always @(posedge clk) begin : result_check
    result_beat_t exp_beat;
    if (!rst && dout_if.valid && dout_if.ready) begin
      beats_seen++;
      if (due_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, value %0d run_last %0b",
                 $time, dout_if.value, dout_if.run_last);
        errors++;
      end else begin
        exp_beat = due_beats.pop_front();
        if (dout_if.value !== exp_beat.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d",
                   $time, exp_beat.value, dout_if.value);
          errors++;
        end
        if (dout_if.run_last !== exp_beat.run_last) begin
          $display("%0t: run_last mismatch, expected %0b, got %0b",
                   $time, exp_beat.run_last, dout_if.run_last);
          errors++;
        end
        if (dout_if.trace_done !== exp_beat.trace_done) begin
          $display("%0t: trace_done mismatch, expected %0b, got %0b",
                   $time, exp_beat.trace_done, dout_if.trace_done);
          errors++;
        end
        if (dout_if.misaligned !== exp_beat.misaligned) begin
          $display("%0t: misaligned mismatch, expected %0b, got %0b",
                   $time, exp_beat.misaligned, dout_if.misaligned);
          errors++;
        end
      end
    end
  end

  // The watchdog ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d result beats still owed",
                 $time, idle_cycles, due_beats.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    rst              <= 1'b1;
    din_if.valid     <= 1'b0;
    din_if.sample    <= '0;
    din_if.trace_end <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_MODE;
    cfg_if.data      <= '0;
    cfg_mode   = MODE_FWD;
    cfg_factor = 6'd1;
    cfg_gain   = UNITY_GAIN;
    clear_trace();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_forward_cases();
    test_adjoint_cases();
    test_factor_change();
    test_mode_change();
    test_backpressure();
    test_full_rate();
    test_random();

    // Let every owed beat arrive, then give stray beats a chance to show.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d sample beats and checked %0d result beats: %0d forward and %0d %s",
             items_sent, beats_seen, fwd_traces, adj_traces, "adjoint traces,");
    $display("%0d misaligned ends, %0d register writes, factors 0 to 63, gain 0 to %s %0d %s",
             misaligned_ends, cfg_writes, "full scale,", holds_done,
             "long receiver hold-offs.");
    $display("%0d errors.", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
